FILE: sv/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Constants and helper functions for the relative float compare.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam logic [31:0] TolResetBits = 32'h358637BD;
  localparam logic [30:0] FltMinBits   = 31'h00800000;
  localparam logic [30:0] FltMaxBits   = 31'h7F7FFFFF;
  localparam logic [30:0] InfBits      = 31'h7F800000;

  // significand with hidden bit
  function automatic logic [23:0] sig24(input logic [30:0] w);
    return {(w[30:23] != 8'd0), w[22:0]};
  endfunction

  // exponent field with subnormals taken as one
  function automatic logic [7:0] exp_eff(input logic [30:0] w);
    return (w[30:23] == 8'd0) ? 8'd1 : w[30:23];
  endfunction

  // non-negative magnitude strictly below the tolerance
  function automatic logic lt_tol(input logic [30:0] mag, input logic [31:0] tol);
    return !tol[31] && (tol[30:0] <= InfBits) && (mag < tol[30:0]);
  endfunction

  // pack and round to nearest even, m holds hidden bit at 26 and g/r/s below
  function automatic logic [30:0] round_pack(input logic [8:0] e, input logic [26:0] m);
    logic [7:0]  field;
    logic        up;
    logic [30:0] base;
    field = m[26] ? e[7:0] : 8'd0;
    up    = m[2] & (m[3] | m[1] | m[0]);
    base  = {field, m[25:3]};
    if (e >= 9'd255) begin
      return InfBits;
    end
    return base + {30'd0, up};
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] cnt;
    cnt = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) begin
        cnt = 5'(26 - i);
      end
    end
    return cnt;
  endfunction

endpackage

FILE: sv/frc_addsub.sv
// ----------------------------------------------------------------------------
// frc_addsub
// Three-stage magnitude sum and difference with round to nearest even.
// ----------------------------------------------------------------------------
module frc_addsub (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] mag_x_i,
  input  logic [30:0] mag_y_i,
  input  logic        sub_i,
  output logic [30:0] sum_o,
  output logic [30:0] diff_o
);

  // stage 1: alignment
  logic [7:0]  ex_d, ey_d, dist_d;
  logic [4:0]  sh_d;
  logic [26:0] ybase_d, yal_d, mask_d, y27_d;
  logic        lost_d;

  logic [7:0]  s1_e_q;
  logic [26:0] s1_x_q, s1_y_q;
  logic        s1_inf_q, s1_sub_q;

  always_comb begin
    ex_d    = frc_pkg::exp_eff(mag_x_i);
    ey_d    = frc_pkg::exp_eff(mag_y_i);
    dist_d  = ex_d - ey_d;
    sh_d    = (dist_d > 8'd27) ? 5'd27 : dist_d[4:0];
    ybase_d = {frc_pkg::sig24(mag_y_i), 3'b000};
    yal_d   = ybase_d >> sh_d;
    mask_d  = ~({27{1'b1}} << sh_d);
    lost_d  = |(ybase_d & mask_d);
    y27_d   = {yal_d[26:1], yal_d[0] | lost_d};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_e_q   <= ex_d;
      s1_x_q   <= {frc_pkg::sig24(mag_x_i), 3'b000};
      s1_y_q   <= y27_d;
      s1_inf_q <= (mag_x_i[30:23] == 8'hFF);
      s1_sub_q <= sub_i;
    end
  end

  // stage 2: add and subtract
  logic [7:0]  s2_e_q;
  logic [27:0] s2_add_q;
  logic [26:0] s2_sub_q;
  logic        s2_inf_q, s2_issub_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_e_q     <= s1_e_q;
      s2_add_q   <= {1'b0, s1_x_q} + {1'b0, s1_y_q};
      s2_sub_q   <= s1_x_q - s1_y_q;
      s2_inf_q   <= s1_inf_q;
      s2_issub_q <= s1_sub_q;
    end
  end

  // stage 3: normalize and round
  logic [26:0] sm_d, dm_d;
  logic [8:0]  se_d, de_d;
  logic [7:0]  em1_d;
  logic [4:0]  lz_d, nsh_d;
  logic [30:0] sum_d, diff_d;
  logic [30:0] sum_q, diff_q;

  always_comb begin
    if (s2_add_q[27]) begin
      sm_d = {s2_add_q[27:2], s2_add_q[1] | s2_add_q[0]};
      se_d = {1'b0, s2_e_q} + 9'd1;
    end else begin
      sm_d = s2_add_q[26:0];
      se_d = {1'b0, s2_e_q};
    end
    em1_d = s2_e_q - 8'd1;
    lz_d  = frc_pkg::lzc27(s2_sub_q);
    nsh_d = ({3'd0, lz_d} < em1_d) ? lz_d : em1_d[4:0];
    dm_d  = s2_sub_q << nsh_d;
    de_d  = {1'b0, s2_e_q} - {4'd0, nsh_d};
    sum_d = frc_pkg::round_pack(se_d, sm_d);
    diff_d = s2_issub_q ? frc_pkg::round_pack(de_d, dm_d) : sum_d;
    if (s2_inf_q) begin
      sum_d  = frc_pkg::InfBits;
      diff_d = frc_pkg::InfBits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q  <= sum_d;
      diff_q <= diff_d;
    end
  end

  assign sum_o  = sum_q;
  assign diff_o = diff_q;

endmodule

FILE: sv/float_relative_compare_top.sv
// ----------------------------------------------------------------------------
// float_relative_compare_top
// Single-precision match test under a relative or absolute tolerance.
// ----------------------------------------------------------------------------
// Takes one operand pair per cycle while the output is not stalled and
// returns one is_close flag per pair.
// The five register stages are: unpack and align, add/subtract, normalize
// and round of magnitude sum and difference, the tolerance midpoint times
// the clamped sum (one 25x24 multiply), and the exact final compare. The
// relative test is done without a divider by comparing the difference with
// the product of the sum and the rounding midpoint below the tolerance. A
// stall at the output holds the whole pipeline. The tolerance register
// resets to 1e-6 and is to be written only while no request is in flight.
module float_relative_compare_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_close_o
);

  typedef struct packed {
    logic nan;
    logic eq;
    logic zero;
    logic mlt;
  } side_t;

  logic [31:0] tol_q;
  logic        adv;
  logic        v1_q, v2_q, v3_q, v4_q, v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= frc_pkg::TolResetBits;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign adv        = !(v5_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: classification and ordering
  logic [30:0] mag_a, mag_b, mag_x, mag_y;
  side_t       side_d, p1_q, p2_q, p3_q;

  always_comb begin
    mag_a       = operand_a_i[30:0];
    mag_b       = operand_b_i[30:0];
    side_d.nan  = (mag_a > frc_pkg::InfBits) || (mag_b > frc_pkg::InfBits);
    side_d.eq   = (operand_a_i == operand_b_i) || (mag_a == 31'd0 && mag_b == 31'd0);
    side_d.zero = (mag_a == 31'd0) || (mag_b == 31'd0);
    side_d.mlt  = frc_pkg::lt_tol(mag_a, tol_q) || frc_pkg::lt_tol(mag_b, tol_q);
    mag_x       = (mag_a >= mag_b) ? mag_a : mag_b;
    mag_y       = (mag_a >= mag_b) ? mag_b : mag_a;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q <= side_d;
      p2_q <= p1_q;
      p3_q <= p2_q;
    end
  end

  logic [30:0] sum, diff;

  frc_addsub u_addsub (
    .clk_i   (clk_i),
    .en_i    (adv),
    .mag_x_i (mag_x),
    .mag_y_i (mag_y),
    .sub_i   (operand_a_i[31] == operand_b_i[31]),
    .sum_o   (sum),
    .diff_o  (diff)
  );

  // stage 4: path selection and midpoint product
  logic        use_abs, tol_fin, tol_inf, diff_inf, known_d, rel_d;
  logic        pow2;
  logic [30:0] sumc;
  logic [24:0] mint;
  logic [10:0] mexp, k_d;
  logic        known_q, rel_q, todd_q;
  logic [48:0] prod_q;
  logic [23:0] dint_q;
  logic [10:0] k_q;

  always_comb begin
    use_abs  = p3_q.zero || (sum < frc_pkg::FltMinBits) || p3_q.mlt;
    tol_fin  = !tol_q[31] && (tol_q[30:0] != 31'd0) && (tol_q[30:0] < frc_pkg::InfBits);
    tol_inf  = (tol_q == {1'b0, frc_pkg::InfBits});
    diff_inf = (diff == frc_pkg::InfBits);
    known_d  = 1'b0;
    rel_d    = 1'b0;
    if (p3_q.nan) begin
      known_d = 1'b0;
    end else if (p3_q.eq) begin
      known_d = 1'b1;
    end else if (use_abs) begin
      known_d = frc_pkg::lt_tol(diff, tol_q);
    end else if (diff_inf) begin
      known_d = 1'b0;
    end else if (tol_inf) begin
      known_d = 1'b1;
    end else begin
      rel_d = tol_fin;
    end
    sumc = (sum >= frc_pkg::InfBits) ? frc_pkg::FltMaxBits : sum;
    pow2 = (tol_q[30:23] >= 8'd2) && (tol_q[22:0] == 23'd0);
    if (pow2) begin
      mint = 25'h1FFFFFF;
      mexp = {3'd0, tol_q[30:23]} - 11'd152;
    end else begin
      mint = {frc_pkg::sig24(tol_q[30:0]), 1'b0} - 25'd1;
      mexp = {3'd0, frc_pkg::exp_eff(tol_q[30:0])} - 11'd151;
    end
    k_d = {3'd0, frc_pkg::exp_eff(diff)} - {3'd0, frc_pkg::exp_eff(sumc)} - mexp;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      known_q <= known_d;
      rel_q   <= rel_d;
      todd_q  <= tol_q[0];
      prod_q  <= mint * frc_pkg::sig24(sumc);
      dint_q  <= frc_pkg::sig24(diff);
      k_q     <= k_d;
    end
  end

  // stage 5: exact compare against the midpoint product
  logic [71:0] lhs, rhs;
  logic        kneg, kbig, relres, is_close_q;

  always_comb begin
    lhs    = {48'd0, dint_q} << k_q[5:0];
    rhs    = {23'd0, prod_q};
    kneg   = k_q[10];
    kbig   = !kneg && (k_q > 11'd48);
    relres = kneg || (!kbig && ((lhs < rhs) || ((lhs == rhs) && todd_q)));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      is_close_q <= rel_q ? relres : known_q;
    end
  end

  assign out_valid_o = v5_q;
  assign is_close_o  = is_close_q;

endmodule

FILE: sv/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks for the relative float compare, bound to the top level.
// ----------------------------------------------------------------------------
module frc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] operand_a_i,
  input logic [31:0] operand_b_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        is_close_o
);

  logic eq_req;

  assign eq_req = in_valid_i && !in_stall_o && (operand_a_i == operand_b_i)
                  && (operand_a_i[30:0] <= 31'h7F800000);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(is_close_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_equal_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eq_req ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> (out_valid_o && is_close_o))
    else $error("equal operands not reported close");

endmodule

bind float_relative_compare_top frc_checker u_frc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .operand_a_i (operand_a_i),
  .operand_b_i (operand_b_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .is_close_o  (is_close_o)
);

FILE: dv/float_relative_compare_checker.sv
// ----------------------------------------------------------------------------
// float_relative_compare_checker
// Watches the request and result channels and checks every is_close flag.
// ----------------------------------------------------------------------------
// Keeps its own copy of the tolerance register and works out each expected
// flag with exact integer arithmetic on values scaled to units of 2^-149, so
// that every rounding step of the single-precision algorithm is reproduced
// without relying on simulator float types. Flags are queued in request order
// and compared with the results as they are taken.
module float_relative_compare_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        is_close_i,
  output int          errors_o,
  output int          pending_o
);

  localparam logic [30:0] MagInf = 31'h7F800000;
  localparam logic [30:0] MagMax = 31'h7F7FFFFF;
  localparam logic [30:0] MagMinNormal = 31'h00800000;

  logic [31:0] tol_bits;
  logic        close_q[$];
  logic        want;

  // magnitude bits to an integer count of 2^-149
  function automatic logic [279:0] to_units(input logic [30:0] w);
    logic [279:0] sig;
    sig = {256'd0, (w[30:23] != 8'd0), w[22:0]};
    if (w[30:23] == 8'd0) return sig;
    return sig << (w[30:23] - 1);
  endfunction

  // integer count of 2^-149 to magnitude bits, nearest even
  function automatic logic [30:0] round_units(input logic [279:0] x);
    int           p;
    int           sh;
    logic [279:0] m;
    logic [279:0] rem_v;
    logic [279:0] half;
    logic [32:0]  r;
    p = -1;
    for (int i = 0; i < 280; i++) begin
      if (x[i]) p = i;
    end
    if (p < 24) return x[30:0];
    sh = p - 23;
    m = x >> sh;
    rem_v = x - (m << sh);
    half = 280'd1 << (sh - 1);
    r = (33'(sh) << 23) + 33'(m[23:0]);
    if (rem_v > half || (rem_v == half && m[0])) r = r + 33'd1;
    if (r >= 33'(MagInf)) return MagInf;
    return r[30:0];
  endfunction

  // non-negative magnitude strictly below the tolerance
  function automatic logic below_tol(input logic [30:0] mag, input logic [31:0] tol);
    return !tol[31] && tol[30:0] <= MagInf && mag < tol[30:0];
  endfunction

  function automatic logic close_flag(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] tol);
    logic [30:0]  ma;
    logic [30:0]  mb;
    logic [279:0] ua;
    logic [279:0] ub;
    logic [30:0]  diff_m;
    logic [30:0]  sum_m;
    logic [639:0] lhs;
    logic [639:0] rhs;
    logic [30:0]  pred;
    ma = a[30:0];
    mb = b[30:0];
    if (ma > MagInf || mb > MagInf) return 1'b0;
    if (a == b || (ma == 31'd0 && mb == 31'd0)) return 1'b1;
    if (ma == MagInf || mb == MagInf) return 1'b0;
    ua = to_units(ma);
    ub = to_units(mb);
    if (a[31] != b[31]) diff_m = round_units(ua + ub);
    else if (ua > ub) diff_m = round_units(ua - ub);
    else diff_m = round_units(ub - ua);
    sum_m = round_units(ua + ub);
    if (ma == 31'd0 || mb == 31'd0 || sum_m < MagMinNormal) return below_tol(diff_m, tol);
    if (below_tol(ma, tol) || below_tol(mb, tol)) return below_tol(diff_m, tol);
    // tolerance here is positive finite or never passes
    if (tol[31] || tol[30:0] == 31'd0 || tol[30:0] >= MagInf) return 1'b0;
    if (diff_m == MagInf) return 1'b0;
    if (sum_m == MagInf) sum_m = MagMax;
    // rounded quotient below tol iff quotient below midpoint under tol, ties to even
    pred = tol[30:0] - 31'd1;
    lhs = {360'd0, to_units(diff_m)} << 150;
    rhs = {360'd0, to_units(sum_m)} * ({360'd0, to_units(pred)} + {360'd0, to_units(tol[30:0])});
    return lhs < rhs || (lhs == rhs && tol[0]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_bits <= frc_pkg::TolResetBits;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) tol_bits <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        close_q.push_back(close_flag(operand_a_i, operand_b_i, tol_bits));
      end
      if (out_valid_i && !out_stall_i) begin
        if (close_q.size() == 0) begin
          $display("%0t: unexpected result is_close=%0b", $time, is_close_i);
          errors_o <= errors_o + 1;
        end else begin
          want = close_q.pop_front();
          if (want !== is_close_i) begin
            $display("%0t: is_close mismatch expected %0b actual %0b", $time, want,
                     is_close_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= close_q.size();
    end
  end

endmodule

FILE: dv/float_relative_compare_top_test.sv
// ----------------------------------------------------------------------------
// float_relative_compare_top_test
// Stimulus and verdict for the relative float compare.
// ----------------------------------------------------------------------------
// Sends directed operand pairs and then random pairs under a series of
// tolerance settings, including zero, negative, NaN, infinite and extreme
// values, with random request gaps and result stalls, one long result stall
// and drains between settings. Checking is done by the checker module.
module float_relative_compare_top_test;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 88;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        is_close_o;
  int          errors;
  int          pending;
  int          cycle_cnt = 0;
  int          req_cnt = 0;
  bit          quiet = 0;
  bit          long_done = 0;
  int          hold_left = 0;
  logic [31:0] specials[16] = '{
    32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000, 32'hFF800001,
    32'h00000001, 32'h807FFFFF, 32'h00800000, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800000,
    32'hBF800000, 32'h358637BD, 32'h00400000, 32'h7FFFFFFF};
  logic [31:0] tol_set[10] = '{
    32'h00000000, 32'h7F800000, 32'h7FC00000, 32'hBF800000, 32'hFFFFFFFF,
    32'h00000001, 32'h7F7FFFFF, 32'h3A83126F, 32'h34000000, 32'h358637BD};

  float_relative_compare_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_close_o  (is_close_o)
  );

  float_relative_compare_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_close_i  (is_close_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[float_relative_compare_top] ERROR");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!long_done && req_cnt >= PhaseItems + 20) begin
      long_done <= 1'b1;
      out_stall_i <= 1'b1;
      hold_left <= 79;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      hold_left <= $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      operand_a_i <= $urandom;
      operand_b_i <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    req_cnt++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_tol(input logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_pair();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] delta;
    int          kind;
    kind = $urandom_range(0, 9);
    a = $urandom;
    b = $urandom;
    if (kind >= 2 && kind <= 6) begin
      a[30:23] = $urandom_range(0, 254);
      delta = $urandom & ((32'd1 << $urandom_range(0, 26)) - 32'd1);
      b = $urandom_range(0, 1) ? a + delta : a - delta;
      if ($urandom_range(0, 7) == 0) b[31] = ~b[31];
    end else if (kind == 7) begin
      a = specials[$urandom_range(0, 15)];
      if ($urandom_range(0, 1) == 1) b = specials[$urandom_range(0, 15)];
    end else if (kind == 8) begin
      a[30:24] = 7'd0;
      b[30:24] = 7'd0;
    end else if (kind == 9) begin
      b = $urandom_range(0, 1) ? a : {~a[31], a[30:0]};
    end
    if ($urandom_range(0, 1) == 1) send_pair(a, b);
    else send_pair(b, a);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 32'd0;
    in_valid_i = 1'b0;
    operand_a_i = 32'd0;
    operand_b_i = 32'd0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zeros, equal and NaN patterns, infinities, extremes, subnormals, near pairs
    send_pair(32'h00000000, 32'h80000000);
    send_pair(32'h3F800000, 32'h3F800000);
    send_pair(32'h7FC00000, 32'h7FC00000);
    send_pair(32'hFFFFFFFF, 32'h3F800000);
    send_pair(32'h7F800000, 32'h7F800000);
    send_pair(32'h7F800000, 32'hFF800000);
    send_pair(32'hFF800000, 32'h3F800000);
    send_pair(32'h7F7FFFFF, 32'h7F7FFFFE);
    send_pair(32'hFF7FFFFF, 32'h7F7FFFFF);
    send_pair(32'h7F7FFFFF, 32'h7F7FFFFF);
    send_pair(32'h00000001, 32'h00000002);
    send_pair(32'h00000000, 32'h00000001);
    send_pair(32'h00800000, 32'h00800001);
    send_pair(32'h007FFFFF, 32'h00800000);
    send_pair(32'h3F800000, 32'h3F800001);
    send_pair(32'h3F800000, 32'h3F800011);
    send_pair(32'h3F800000, 32'h3F800008);
    send_pair(32'h358637BD, 32'h00000000);
    send_pair(32'h35000000, 32'h3F800000);
    send_pair(32'h80000000, 32'h7FFFFFFF);
    send_pair(32'hBF800000, 32'h3F800000);
    send_pair(32'h00000000, 32'hFFFFFFFF);

    for (int ph = 0; ph <= 10; ph++) begin
      if (ph > 0) begin
        drain();
        if (ph == 10) quiet = 1;
        write_tol(ph == 10 ? $urandom_range(32'h30000000, 32'h3E000000) : tol_set[ph - 1]);
      end
      for (int i = 0; i < PhaseItems - (ph == 0 ? 22 : 0); i++) begin
        random_pair();
      end
    end
    drain();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d requests under 11 tolerance settings", req_cnt);
    $display("tolerances included zero, negative, NaN, infinite and extreme values");
    if (errors == 0 && pending == 0) begin
      $display("[float_relative_compare_top] OK");
    end else begin
      $display("[float_relative_compare_top] ERROR");
    end
    $finish;
  end

endmodule
